/* sv/cdoy_pkg.sv */
package cdoy_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam int          DIV100_MUL  = 5243;
  localparam int          DIV7_MUL    = 73;
  localparam logic [12:0] YEAR_BASE   = 13'd1900;
  localparam logic [8:0]  DOY_MAX     = 9'd366;
  localparam logic [8:0]  DOY_LEAP    = 9'd366;
  localparam logic [8:0]  DOY_COMMON  = 9'd365;
  localparam logic [3:0]  MONTH_LAST  = 4'd11;
  localparam logic [3:0]  WALK_MAX    = 4'd13;
  localparam logic [8:0]  WDAY_BIAS   = 9'd55;
  localparam logic [8:0]  DAYS_WEEK   = 9'd7;
  localparam logic signed [3:0] WDAY_MISSING = -4'sd1;

  localparam logic MODE_TO_YDAY = 1'b0;
  localparam logic MODE_TO_DATE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_BAD_YEAR,
    STATUS_NO_WDAY
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAP_Q,
    ST_LEAP_R,
    ST_SUM,
    ST_WALK,
    ST_WD_DIV,
    ST_WD_SUM,
    ST_WD_MOD,
    ST_WD_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic leap_q;
    logic leap_r;
    logic sum_step;
    logic walk_step;
    logic wd_div;
    logic wd_sum;
    logic wd_mod;
    logic wd_fix;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic err;
    logic sum_done;
    logic walk_done;
    logic out_stall;
  } sts_t;

  // month index 12 is January of the following year
  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    unique case (idx) inside
      4'd1:                     len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // 26 * (m + 1) / 10 for month number m = tm + 1, with January and February taken as months 13 and 14
  function automatic logic [5:0] month_offset(input logic [3:0] mon);
    logic [5:0] off;
    unique case (mon)
      4'd0:    off = 6'd36;
      4'd1:    off = 6'd39;
      4'd2:    off = 6'd10;
      4'd3:    off = 6'd13;
      4'd4:    off = 6'd15;
      4'd5:    off = 6'd18;
      4'd6:    off = 6'd20;
      4'd7:    off = 6'd23;
      4'd8:    off = 6'd26;
      4'd9:    off = 6'd28;
      4'd10:   off = 6'd31;
      4'd11:   off = 6'd33;
      4'd12:   off = 6'd36;
      default: off = 6'd0;
    endcase
    return off;
  endfunction

endpackage

/* sv/cdoy_ctrl.sv */
module cdoy_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  cdoy_pkg::sts_t  sts,
  output cdoy_pkg::cmd_t  cmd
);
  import cdoy_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_LEAP_Q;
        end
      end
      ST_LEAP_Q: begin
        cmd.leap_q = 1'b1;
        state_next = ST_LEAP_R;
      end
      ST_LEAP_R: begin
        cmd.leap_r = 1'b1;
        if (sts.func) begin
          state_next = ST_WALK;
        end else if (sts.err) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sts.sum_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      ST_WALK: begin
        if (sts.walk_done) begin
          state_next = ST_WD_DIV;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_WD_DIV: begin
        cmd.wd_div = 1'b1;
        state_next = ST_WD_SUM;
      end
      ST_WD_SUM: begin
        cmd.wd_sum = 1'b1;
        state_next = ST_WD_MOD;
      end
      ST_WD_MOD: begin
        cmd.wd_mod = 1'b1;
        state_next = ST_WD_FIX;
      end
      ST_WD_FIX: begin
        cmd.wd_fix = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_load_from_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_LEAP_Q)
    else $error("load did not start the leap check");

  a_out_not_stalled: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_stall)
    else $error("result loaded over a pending transfer");

  a_walk_only_mode1: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> sts.func)
    else $error("month walk in mode 0");

endmodule

/* sv/cdoy_datapath.sv */
module cdoy_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  cdoy_pkg::cmd_t                      cmd,
  output cdoy_pkg::sts_t                      sts,
  input  logic [cdoy_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cdoy_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import cdoy_pkg::*;

  logic [10:0]        in_year;
  logic [8:0]         in_count;
  logic [8:0]         in_count_sat;
  logic [3:0]         in_mon;
  logic [4:0]         in_mday;
  logic [3:0]         in_wday;

  logic               func;
  logic [10:0]        year;
  logic [8:0]         count;
  logic [3:0]         mon_in;
  logic [4:0]         mday_in;
  logic signed [3:0]  wday_in;
  logic               leap;
  logic [4:0]         leap_q;
  logic signed [9:0]  acc;
  logic [3:0]         idx;
  logic [4:0]         last_len;
  logic [4:0]         wd_c;
  logic [8:0]         wsum;
  logic [6:0]         wq;
  logic [2:0]         wday;

  logic [12:0]        full_s;
  logic [11:0]        full;
  logic [24:0]        leap_prod;
  logic [6:0]         leap_rem;
  logic               leap_calc;
  logic [4:0]         cur_len;
  logic signed [9:0]  cur_len_s;
  logic [3:0]         lim;
  logic [3:0]         mon_w;
  logic signed [9:0]  mday_sum;
  logic [4:0]         mday_w;
  logic [11:0]        ty;
  logic [24:0]        ty_prod;
  logic [6:0]         ty_rem;
  logic [8:0]         w_pos;
  logic [8:0]         w_next;
  logic [15:0]        mod_prod;
  logic [8:0]         wd_r;
  logic [8:0]         wd_r_fix;

  logic signed [11:0] year_ext;
  logic signed [10:0] doy_raw;
  logic [8:0]         thr;
  logic               roll;

  status_t            r_status;
  logic [3:0]         r_mon;
  logic [4:0]         r_mday;
  logic [2:0]         r_wday;
  logic [8:0]         r_yday;
  logic [11:0]        r_year;
  logic               r_roll;

  status_t            o_status;
  logic [3:0]         o_mon;
  logic [4:0]         o_mday;
  logic [2:0]         o_wday;
  logic [8:0]         o_yday;
  logic [11:0]        o_year;
  logic               o_roll;

  assign in_year      = s_tdata[10:0];
  assign in_count     = s_tdata[19:11];
  assign in_mon       = s_tdata[23:20];
  assign in_mday      = s_tdata[28:24];
  assign in_wday      = s_tdata[32:29];
  assign in_count_sat = (in_count > DOY_MAX) ? DOY_MAX : in_count;

  assign full_s    = {{2{year[10]}}, year} + YEAR_BASE;
  assign full      = full_s[11:0];
  assign leap_prod = 25'(full) * 25'(DIV100_MUL);
  assign leap_rem  = 7'(full - 12'(leap_q) * 12'd100);
  assign leap_calc = (leap_rem != 7'd0 && full[1:0] == 2'd0) ||
                     (leap_rem == 7'd0 && leap_q[1:0] == 2'd0);

  assign cur_len   = month_len(idx, leap);
  assign cur_len_s = $signed({5'b0, cur_len});
  assign lim       = (mon_in > MONTH_LAST) ? MONTH_LAST : mon_in;

  assign mon_w    = idx - 4'd1;
  assign mday_sum = acc + $signed({5'b0, last_len});
  assign mday_w   = mday_sum[4:0];

  assign ty       = (mon_w < 4'd2) ? full - 12'd1 : full;
  assign ty_prod  = 25'(ty) * 25'(DIV100_MUL);
  assign ty_rem   = 7'(ty - 12'(wd_c) * 12'd100);
  assign w_pos    = WDAY_BIAS + 9'(wd_c[4:2]) + 9'(ty_rem) + 9'(ty_rem[6:2]) +
                    9'(month_offset(mon_w)) + 9'(mday_w);
  assign w_next   = w_pos - 9'({wd_c, 1'b0});
  assign mod_prod = 16'(wsum) * 16'(DIV7_MUL);
  assign wd_r     = wsum - 9'(wq) * DAYS_WEEK;
  assign wd_r_fix = (wd_r >= DAYS_WEEK) ? wd_r - DAYS_WEEK : wd_r;

  assign sts.func      = func;
  assign sts.err       = year[10] || (wday_in == WDAY_MISSING);
  assign sts.sum_done  = (idx >= lim);
  assign sts.walk_done = (acc <= 10'sd0) || (idx == WALK_MAX);
  assign sts.out_stall = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func     <= s_tuser;
      year     <= in_year;
      count    <= in_count_sat;
      mon_in   <= in_mon;
      mday_in  <= in_mday;
      wday_in  <= in_wday;
      acc      <= s_tuser ? $signed(10'(in_count_sat) + 10'd1) : 10'sd0;
      last_len <= '0;
    end else if (cmd.sum_step) begin
      acc <= acc + cur_len_s;
    end else if (cmd.walk_step) begin
      acc      <= acc - cur_len_s;
      last_len <= cur_len;
    end
    if (cmd.leap_q) begin
      leap_q <= leap_prod[23:19];
    end
    if (cmd.leap_r) begin
      leap <= leap_calc;
    end
    if (cmd.wd_div) begin
      wd_c <= ty_prod[23:19];
    end
    if (cmd.wd_sum) begin
      wsum <= w_next;
    end
    if (cmd.wd_mod) begin
      wq <= mod_prod[15:9];
    end
    if (cmd.wd_fix) begin
      wday <= wd_r_fix[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load) begin
      idx <= '0;
    end else if (cmd.sum_step || cmd.walk_step) begin
      idx <= idx + 4'd1;
    end
  end

  assign year_ext = {year[10], year};
  assign doy_raw  = {acc[9], acc} + $signed({6'b0, mday_in}) - 11'sd1;
  assign thr      = leap ? DOY_LEAP : DOY_COMMON;
  assign roll     = (count >= thr);

  always_comb begin
    r_status = STATUS_OK;
    r_mon    = mon_in;
    r_mday   = mday_in;
    r_wday   = '0;
    r_yday   = '0;
    r_year   = year_ext;
    r_roll   = 1'b0;
    if (!func) begin
      if (year[10]) begin
        r_status = STATUS_BAD_YEAR;
      end else if (wday_in == WDAY_MISSING) begin
        r_status = STATUS_NO_WDAY;
      end else if (doy_raw < 11'sd0) begin
        r_yday = '0;
      end else if (doy_raw > $signed({2'b0, DOY_MAX})) begin
        r_yday = DOY_MAX;
      end else begin
        r_yday = doy_raw[8:0];
      end
    end else begin
      r_wday = wday;
      if (roll) begin
        r_mon  = '0;
        r_mday = 5'd1;
        r_yday = count - thr;
        r_year = year_ext + 12'sd1;
        r_roll = 1'b1;
      end else begin
        r_mon  = mon_w;
        r_mday = mday_w;
        r_yday = count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status <= r_status;
      o_mon    <= r_mon;
      o_mday   <= r_mday;
      o_wday   <= r_wday;
      o_yday   <= r_yday;
      o_year   <= r_year;
      o_roll   <= r_roll;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {4'b0, o_roll, o_year, o_yday, o_wday, o_mday, o_mon, o_status};

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= WALK_MAX)
    else $error("month index past the walk limit");

  a_roll_jan1: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_roll |-> o_mon == 4'd0 && o_mday == 5'd1 && o_status == STATUS_OK)
    else $error("rollover result not January 1");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("loaded result not presented");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> o_wday < 3'd7 && o_yday <= DOY_MAX)
    else $error("result field out of range");

endmodule

/* sv/calendar_day_of_year_converter_core.sv */
// Gregorian day-of-year and weekday converter, year counted from 1900.
// Input channel s_*: one request per transfer; s_tuser selects the mode
// (0 = month and day to day of year, 1 = day count to month, day, weekday).
// Output channel m_*: exactly one result per request, in request order.
// Each request runs the leap-year check, then the month loop of the
// shared add/subtract unit, then fixed steps, before m_tvalid:
//   mode 0, year or weekday error: leap check only, no month loop
//   mode 0: month loop over the months before month_in (months 0..11)
//   mode 1: month walk (1..13 months), then the weekday steps
// The two divisions by 100 and the one by 7 are reciprocal multiplies,
// one step each in the leap-year and weekday sequence.
// One request is in flight at a time; s_tready rises again the cycle after
// the result enters the output register, so the next request is taken while
// the previous result still waits on m_tready.
// A stalled receiver holds the result in the output register; the block
// finishes the current request and waits before loading a new result.
// Reset clears the sequencer, the month index and the output valid; no clearing pass.
module calendar_day_of_year_converter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // year_since_1900[10:0], day_count[19:11], month_in[23:20],
  // day_of_month_in[28:24], weekday_in[32:29], zero[39:33]
  input  logic [cdoy_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[1:0], month_out[5:2], day_of_month_out[10:6], weekday_out[13:11],
  // day_of_year_out[22:14], year_out[34:23], rolled_over[35], zero[39:36]
  output logic [cdoy_pkg::OUT_DATA_W-1:0] m_tdata
);
  import cdoy_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cdoy_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdoy_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
